// ===== src/b85_pkg.sv =====
// shared types, status codes and the character-to-digit table for the base85 decoder
// no dependencies; used by every module in src
`default_nettype none

package b85_pkg;

  localparam int unsigned B85_QUEUE_DEPTH = 4;
  localparam int unsigned B85_CAP_W       = 24;
  localparam int unsigned B85_GROUP_W     = 26;  // four digits stay below 85^4
  localparam int unsigned B85_FULL_W      = 33;  // five digits stay below 85^5
  localparam logic [7:0]  B85_NO_DIGIT    = 8'd128;
  localparam logic [B85_FULL_W-1:0] B85_RADIX = 33'd85;
  localparam logic [B85_CAP_W-1:0]  B85_CAP_RESET = 24'hFFFFFF;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_FULL     = 2'd3
  } b85_status_e;

  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_END  = 1'b1
  } b85_cmd_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } b85_kind_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
  } b85_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [23:0] byte_count;
    logic        last;
  } b85_out_t;

  // queued job: a decoded word, or a summary whose count sits in word[23:0]
  typedef struct packed {
    logic        is_sum;
    logic [1:0]  status;
    logic [31:0] word;
  } b85_job_t;

  // handshake between queue and back end
  typedef struct packed {
    logic     valid;
    b85_job_t job;
  } b85_head_t;

  function automatic logic [7:0] b85_digit(input logic [7:0] c);
    logic [7:0] d;
    unique case (c) inside
      [8'h30:8'h39]: d = c - 8'd48;
      [8'h41:8'h5A]: d = c - 8'd55;
      [8'h61:8'h7A]: d = c - 8'd61;
      8'h21: d = 8'd62;
      8'h23: d = 8'd63;
      8'h24: d = 8'd64;
      8'h25: d = 8'd65;
      8'h26: d = 8'd66;
      8'h28: d = 8'd67;
      8'h29: d = 8'd68;
      8'h2A: d = 8'd69;
      8'h2B: d = 8'd70;
      8'h2D: d = 8'd71;
      8'h3B: d = 8'd72;
      8'h3C: d = 8'd73;
      8'h3D: d = 8'd74;
      8'h3E: d = 8'd75;
      8'h3F: d = 8'd76;
      8'h40: d = 8'd77;
      8'h5E: d = 8'd78;
      8'h5F: d = 8'd79;
      8'h60: d = 8'd80;
      8'h7B: d = 8'd81;
      8'h7C: d = 8'd82;
      8'h7D: d = 8'd83;
      8'h7E: d = 8'd84;
      default: d = B85_NO_DIGIT;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/b85_front.sv =====
// front end: accepts characters, accumulates groups, applies stop rules, queues jobs
// depends on b85_pkg
`default_nettype none

module b85_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire b85_pkg::b85_in_t  in_data_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [23:0]       cfg_data_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output b85_pkg::b85_job_t      push_job_o
);
  import b85_pkg::*;

  logic [B85_CAP_W-1:0]   cap_q;
  logic [2:0]             cnt_q, cnt_d;
  logic [B85_GROUP_W-1:0] gv_q, gv_d;
  logic                   stopped_q, stopped_d;
  b85_status_e            reason_q, reason_d;
  logic [B85_CAP_W-1:0]   bytes_q, bytes_d;

  logic                   accept;
  logic [7:0]             digit;
  logic [B85_FULL_W-1:0]  acc;
  logic                   cap_fail;

  assign in_stall_o  = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  assign digit    = b85_digit(in_data_i.char_code);
  assign acc      = {7'b0, gv_q} * B85_RADIX + {25'b0, digit};
  assign cap_fail = ({1'b0, bytes_q} + 25'd4) > {1'b0, cap_q};

  always_comb begin
    cnt_d      = cnt_q;
    gv_d       = gv_q;
    stopped_d  = stopped_q;
    reason_d   = reason_q;
    bytes_d    = bytes_q;
    push_o     = 1'b0;
    push_job_o = '0;
    if (accept) begin
      if (in_data_i.cmd == CMD_END) begin
        push_o            = 1'b1;
        push_job_o.is_sum = 1'b1;
        push_job_o.status = reason_q;
        push_job_o.word   = {8'b0, bytes_q};
        cnt_d             = '0;
        gv_d              = '0;
        stopped_d         = 1'b0;
        reason_d          = STAT_OK;
        bytes_d           = '0;
      end else if (!stopped_q) begin
        if (digit[7]) begin
          stopped_d = 1'b1;
          reason_d  = STAT_INVALID;
        end else if (cnt_q < 3'd4) begin
          gv_d  = acc[B85_GROUP_W-1:0];
          cnt_d = cnt_q + 3'd1;
        end else begin
          // fifth digit closes the group
          cnt_d = '0;
          gv_d  = '0;
          if (cap_fail) begin
            stopped_d = 1'b1;
            reason_d  = STAT_FULL;
          end else if (acc[B85_FULL_W-1]) begin
            stopped_d = 1'b1;
            reason_d  = STAT_OVERFLOW;
          end else begin
            push_o          = 1'b1;
            push_job_o.word = acc[31:0];
            bytes_d         = bytes_q + 24'd4;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= B85_CAP_RESET;
      cnt_q     <= '0;
      gv_q      <= '0;
      stopped_q <= 1'b0;
      reason_q  <= STAT_OK;
      bytes_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      cnt_q     <= cnt_d;
      gv_q      <= gv_d;
      stopped_q <= stopped_d;
      reason_q  <= reason_d;
      bytes_q   <= bytes_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("digit count out of range");
  a_reason_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stopped_q |-> reason_q == STAT_OK)
    else $error("stop reason set while running");
  a_push_acc: assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> accept)
    else $error("job pushed without an accepted item");
  a_bytes_al: assert property (@(posedge clk_i) disable iff (!rst_ni) bytes_q[1:0] == 2'b00)
    else $error("byte count not a multiple of four");
`endif

endmodule

`default_nettype wire

// ===== src/b85_queue.sv =====
// small job queue between front and back end
// depends on b85_pkg
`default_nettype none

module b85_queue #(
  parameter int unsigned Depth = b85_pkg::B85_QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire b85_pkg::b85_job_t  push_job_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output b85_pkg::b85_head_t      head_o
);
  import b85_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(Depth);

  b85_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == DepthC);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  a_no_udf: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_o.valid)
    else $error("pop from empty queue");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DepthC)
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== src/b85_back.sv =====
// back end: splits queued words into bytes, forms summaries, drives the output register
// depends on b85_pkg
`default_nettype none

module b85_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire b85_pkg::b85_head_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output b85_pkg::b85_out_t       out_data_o
);
  import b85_pkg::*;

  logic       out_valid_q, out_valid_d;
  b85_out_t   out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic [7:0] sel_byte;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.job.word[31:24];
      2'd1:    sel_byte = head_i.job.word[23:16];
      2'd2:    sel_byte = head_i.job.word[15:8];
      default: sel_byte = head_i.job.word[7:0];
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_i.valid;
      if (head_i.valid) begin
        out_d = '0;
        if (head_i.job.is_sum) begin
          out_d.kind       = KIND_SUMMARY;
          out_d.status     = head_i.job.status;
          out_d.byte_count = head_i.job.word[23:0];
          out_d.last       = 1'b1;
          pop_o            = 1'b1;
        end else begin
          out_d.kind      = KIND_DATA;
          out_d.data_byte = sel_byte;
          out_d.last      = (idx_q == 2'd3);
          pop_o           = (idx_q == 2'd3);
          idx_d           = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> head_i.valid && !head_i.job.is_sum)
    else $error("byte split lost its word");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && out_q.last)
    else $error("job popped without a final result");
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_SUMMARY |-> out_q.last)
    else $error("summary without last flag");
`endif

endmodule

`default_nettype wire

// ===== src/base85_stream_decoder.sv =====
// top level of the base85 stream decoder: front end, job queue, back end
// depends on b85_pkg, b85_front, b85_queue, b85_back
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | b85_in_t  (cmd, char_code)
//  out     | output    | out_valid_o / out_stall_i| b85_out_t (kind, data_byte, status,
//          |           |                          |            byte_count, last)
//  cfg     | input     | cfg_valid_i / cfg_ready_o| out_capacity, 24 bits
//
// one input item is taken per cycle while the job queue has room
// a complete group leaves as four data bytes and a summary as a single result;
// the output register and its byte splitter pace both, and an output stall holds them
// reset is asynchronous and clears all stream state; capacity returns to 16777215
// a stall on the output fills the queue, then stalls the input

`default_nettype none

module base85_stream_decoder #(
  parameter int unsigned QueueDepth = b85_pkg::B85_QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire b85_pkg::b85_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output b85_pkg::b85_out_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [23:0]       cfg_data_i
);
  import b85_pkg::*;

  logic      q_full;
  logic      push;
  b85_job_t  push_job;
  logic      pop;
  b85_head_t head;

  b85_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  b85_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head)
  );

  b85_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for base85_stream_decoder: directed and random character streams
// depends on b85_pkg and the rtl in src; predicts every output word and compares per field

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b85_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;
  // punctuation part of the alphabet, digits 62..84, first symbol in the top byte
  localparam logic [23*8-1:0] PUNCT = {
    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h3B, 8'h3C,
    8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  b85_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  b85_out_t    out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [23:0] cfg_data_i;

  // predictor state
  logic [23:0] cap_bytes;
  logic [2:0]  digits_held;
  logic [31:0] partial_value;
  bit          halted;
  b85_status_e halt_status;
  logic [23:0] emitted_bytes;

  logic [7:0]  digit_lut [0:127];
  logic [7:0]  char_lut [0:84];
  b85_out_t    decoded_q [$];

  bit          idle_on = 1'b1;
  int          hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;

  base85_stream_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    for (int c = 0; c < 128; c++) digit_lut[c] = B85_NO_DIGIT;
    for (int i = 0; i < 10; i++) digit_lut[8'h30 + i] = 8'(i);
    for (int i = 0; i < 26; i++) begin
      digit_lut[8'h41 + i] = 8'(10 + i);
      digit_lut[8'h61 + i] = 8'(36 + i);
    end
    for (int i = 0; i < 23; i++) digit_lut[PUNCT[(22 - i)*8 +: 8]] = 8'(62 + i);
    for (int c = 0; c < 128; c++) begin
      if (digit_lut[c] != B85_NO_DIGIT) char_lut[digit_lut[c]] = 8'(c);
    end
  end

  // ---------------------------------------------------------------------------
  // predictor

  function automatic void expect_result(logic kind, logic [7:0] data, logic [1:0] status,
                                        logic [23:0] count, logic last);
    b85_out_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.status     = status;
    r.byte_count = count;
    r.last       = last;
    decoded_q.push_back(r);
  endfunction

  function automatic void decode_item(b85_in_t w);
    logic [7:0]  d;
    logic [63:0] full;
    if (w.cmd == CMD_END) begin
      expect_result(KIND_SUMMARY, 8'h00, halt_status, emitted_bytes, 1'b1);
      digits_held   = '0;
      partial_value = '0;
      halted        = 1'b0;
      halt_status   = STAT_OK;
      emitted_bytes = '0;
      return;
    end
    if (halted) return;
    d = w.char_code[7] ? B85_NO_DIGIT : digit_lut[w.char_code[6:0]];
    if (d == B85_NO_DIGIT) begin
      halted      = 1'b1;
      halt_status = STAT_INVALID;
    end else if (digits_held < 3'd4) begin
      partial_value = partial_value * 32'd85 + 32'(d);
      digits_held   = digits_held + 3'd1;
    end else begin
      full          = 64'(partial_value) * 64'd85 + 64'(d);
      digits_held   = '0;
      partial_value = '0;
      // capacity is tested before overflow
      if ({1'b0, emitted_bytes} + 25'd4 > {1'b0, cap_bytes}) begin
        halted      = 1'b1;
        halt_status = STAT_FULL;
      end else if (full > 64'hFFFF_FFFF) begin
        halted      = 1'b1;
        halt_status = STAT_OVERFLOW;
      end else begin
        for (int i = 0; i < 4; i++) begin
          expect_result(KIND_DATA, full[(3 - i)*8 +: 8], STAT_OK, 24'd0, i == 3);
        end
        emitted_bytes = emitted_bytes + 24'd4;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (n_errors < 100) begin
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    b85_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_data_o, 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_data_o.kind !== want.kind)
          report_mismatch("kind", out_data_o.kind, want.kind);
        if (out_data_o.data_byte !== want.data_byte)
          report_mismatch("data_byte", out_data_o.data_byte, want.data_byte);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.byte_count !== want.byte_count)
          report_mismatch("byte_count", out_data_o.byte_count, want.byte_count);
        if (out_data_o.last !== want.last)
          report_mismatch("last", out_data_o.last, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, decoded_q.size());
      $display("base85_stream_decoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall, or a long hold-off when one is requested

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = idle_on && ($urandom_range(99) < 37);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side

  task automatic send_word(input b85_in_t w);
    if (idle_on && $urandom_range(99) < 37) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    decode_item(w);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] c);
    b85_in_t w;
    w.cmd       = CMD_CHAR;
    w.char_code = c;
    send_word(w);
  endtask

  task automatic send_end(input logic [7:0] c);
    b85_in_t w;
    w.cmd       = CMD_END;
    w.char_code = c;
    send_word(w);
  endtask

  function automatic logic [7:0] pick_invalid();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (!c[7] && digit_lut[c[6:0]] != B85_NO_DIGIT);
    return c;
  endfunction

  // lead digits mostly stay below 82 so that most groups decode
  function automatic logic [7:0] pick_digit_char(bit lead);
    int unsigned d;
    d = (lead && $urandom_range(99) < 85) ? $urandom_range(81) : $urandom_range(84);
    return char_lut[d];
  endfunction

  task automatic send_stream();
    int unsigned groups, flavor, cut;
    groups = $urandom_range(0, 6);
    flavor = $urandom_range(99);
    cut    = $urandom_range(0, groups * 5);
    for (int g = 0; g < groups; g++) begin
      for (int k = 0; k < 5; k++) begin
        if (flavor < 12 && g * 5 + k == cut) send_char(pick_invalid());
        send_char(pick_digit_char(k == 0));
      end
    end
    if (flavor >= 12 && flavor < 24) begin
      // partial group left at the end
      repeat ($urandom_range(1, 4)) send_char(pick_digit_char(1'b0));
    end else if (flavor >= 24 && flavor < 30) begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
    end
    send_end(8'($urandom_range(255)));
  endtask

  task automatic run_streams(input int unsigned n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) send_stream();
  endtask

  // wait for every expected word, then for any word still inside the pipe
  task automatic settle();
    in_valid_i = 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [23:0] value);
    settle();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cap_bytes = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_directed_streams();
    string seq;
    // largest group, group one above it, then a char after the stop
    seq = "|NsC0|NsC10";
    for (int i = 0; i < seq.len(); i++) send_char(seq[i]);
    send_end(8'h00);
    // char outside the alphabet mid-group, later chars ignored
    send_char("a");
    send_char(8'h22);
    send_char("1");
    send_end(8'hFF);
    send_char(8'h80);
    send_end(8'h55);
    // trailing partial group is dropped
    send_char("Z");
    send_char("z");
    send_end(8'hAA);
    send_end(8'h00);
  endtask

  task automatic test_random_streams();
    run_streams(60);
  endtask

  task automatic test_capacity_limits();
    write_capacity(24'd0);
    run_streams(40);
    repeat (4) begin
      write_capacity(24'($urandom_range(1, 24)));
      run_streams(20);
    end
    write_capacity(24'($urandom_range(24'hFFFFFF)));
    run_streams(50);
    write_capacity(24'hFFFFFF);
    run_streams(40);
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    run_streams(80);
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    settle();
    hold_left = 200;
    for (int g = 0; g < 6; g++) begin
      for (int k = 0; k < 5; k++) send_char(pick_digit_char(1'b0));
    end
    send_end(8'h00);
    settle();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    cap_bytes     = B85_CAP_RESET;
    digits_held   = '0;
    partial_value = '0;
    halted        = 1'b0;
    halt_status   = STAT_OK;
    emitted_bytes = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_streams();
    test_random_streams();
    test_output_backpressure();
    test_no_idle_stretch();
    test_capacity_limits();

    settle();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("base85_stream_decoder regression: pass");
    end else begin
      $display("base85_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/b85_pkg.sv
src/b85_front.sv
src/b85_queue.sv
src/b85_back.sv
src/base85_stream_decoder.sv
tb/sv/tb.sv
